// File: src/cosol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosol_pkg
// Shared types and codes for the count-ordered self-organizing key table.
// ----------------------------------------------------------------------------
package cosol_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W = 6;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_APPENDED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
  } result_t;

endpackage

// File: src/count_ordered_self_organizing_list_top.sv
`timescale 1ns / 1ps
// Searches scan the entry store from the head, one read per cycle, and a hit
//   then bubbles toward the head. One item is handled at a time: a new item
//   is accepted only after the engine has passed on the previous result.
// Reset clears the fill level and control; the entry store is not cleared.
// ----------------------------------------------------------------------------
// count_ordered_self_organizing_list_top
// Key table ordered by search counts, held in one entry memory, with a
// registered result word stage.
// ----------------------------------------------------------------------------
module count_ordered_self_organizing_list_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [5:0]         position
);
  import cosol_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  cosol_engine #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .key(key),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  cosol_ram #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        status    <= res.status;
        position  <= res.position;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/cosol_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosol_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cosol_ram #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cosol_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output cosol_pkg::entry_t rdata
);
  import cosol_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cosol_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosol_engine
// Sequencer: appends at the tail, scans from the head, then bubbles the hit
// entry toward the head by read-compare-write steps on the entry store.
// ----------------------------------------------------------------------------
module cosol_engine #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic signed [31:0]       key,
  output logic                     res_valid,
  input  logic                     res_ready,
  output cosol_pkg::result_t       res,
  output logic                     we,
  output logic [AW-1:0]            waddr,
  output cosol_pkg::entry_t        wdata,
  output logic [AW-1:0]            raddr,
  input  cosol_pkg::entry_t        rdata
);
  import cosol_pkg::*;

  localparam logic [AW:0] FULL_LEVEL = (AW+1)'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_MOVE,
    S_PLACE,
    S_FINISH
  } state_t;

  state_t            state;
  logic [AW:0]       fill;
  logic [AW:0]       idx;
  logic [AW-1:0]     idx_d;
  logic              vld;
  logic [AW-1:0]     j;
  logic [KEY_W-1:0]  srch_key;
  entry_t            hit_e;
  logic [STAT_W-1:0] status_r;
  logic [POS_W-1:0]  pos_r;

  logic              match;
  logic              last;
  logic              lt;
  logic [CNT_W-1:0]  cnt_inc;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FINISH);
  assign res.status   = status_r;
  assign res.position = pos_r;

  assign match   = vld && (rdata.key == srch_key);
  assign last    = vld && (({1'b0, idx_d} + (AW+1)'(1)) == fill);
  assign lt      = (rdata.cnt < hit_e.cnt);
  assign cnt_inc = (rdata.cnt == '1) ? rdata.cnt : rdata.cnt + CNT_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = j;
    wdata = hit_e;
    raddr = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid && kind == KIND_APPEND && fill < FULL_LEVEL) begin
          we        = 1'b1;
          waddr     = fill[AW-1:0];
          wdata.key = unsigned'(key);
          wdata.cnt = '0;
        end
      end
      S_SCAN: raddr = idx[AW-1:0];
      S_LOAD: raddr = j - AW'(1);
      S_MOVE: begin
        we    = 1'b1;
        raddr = j - AW'(2);
        if (lt) begin
          wdata = rdata;
        end
      end
      S_PLACE: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      vld   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos_r <= '0;
            if (kind == KIND_SEARCH) begin
              if (fill == '0) begin
                status_r <= ST_NOT_FOUND;
                state    <= S_FINISH;
              end else begin
                srch_key <= unsigned'(key);
                idx      <= '0;
                vld      <= 1'b0;
                state    <= S_SCAN;
              end
            end else begin
              if (fill < FULL_LEVEL) begin
                fill     <= fill + (AW+1)'(1);
                status_r <= ST_APPENDED;
              end else begin
                status_r <= ST_FULL;
              end
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          // one read issued per cycle, compare uses the previous read's registered data
          vld   <= (idx < fill);
          idx_d <= idx[AW-1:0];
          if (idx < fill) begin
            idx <= idx + (AW+1)'(1);
          end
          if (match) begin
            vld       <= 1'b0;
            hit_e.key <= rdata.key;
            hit_e.cnt <= cnt_inc;
            j         <= idx_d;
            pos_r     <= POS_W'(idx_d);
            status_r  <= ST_FOUND;
            state     <= (idx_d == '0) ? S_PLACE : S_LOAD;
          end else if (last) begin
            vld      <= 1'b0;
            status_r <= ST_NOT_FOUND;
            state    <= S_FINISH;
          end
        end
        S_LOAD: state <= S_MOVE;
        S_MOVE: begin
          // shift the smaller predecessor back one slot, or drop the hit here
          if (lt) begin
            j <= j - AW'(1);
            if (j == AW'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_PLACE: state <= S_FINISH;
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
